// ----- sv/brfs_pkg.sv -----
// Shared constants, types and pointer helpers for the byte ring FIFO with search.
package brfs_pkg;

  // Storage depth and the widths derived from it.
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  // Item field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FLD_W  = 10;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 2;

  // Input beat layout: wr_byte, search_byte, search_offset from the lowest bit up.
  localparam int unsigned IN_WR_LSB  = 0;
  localparam int unsigned IN_SB_LSB  = BYTE_W;
  localparam int unsigned IN_SO_LSB  = 2 * BYTE_W;
  localparam int unsigned IN_DATA_W  = ((2 * BYTE_W + FLD_W + 7) / 8) * 8;

  // Output beat layout: rd_byte, found_offset, used_count, free_count.
  localparam int unsigned OUT_USED_W = BYTE_W + 3 * FLD_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef logic [ADDR_W-1:0] ptr_t;
  typedef logic [FLD_W-1:0]  fld_t;

  localparam ptr_t              LAST_SLOT = ptr_t'(DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(DEPTH);

  // Operation selected by tuser on the input side.
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  // Result status carried in tuser on the output side.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic go_read;
    logic go_scan;
    logic scan_done;
  } ctrl_stat_t;

  // Advance a pointer by one, wrapping at the end of the store.
  function automatic ptr_t ptr_inc(ptr_t p);
    if (p == LAST_SLOT) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  // Add an offset to a pointer modulo the depth.
  function automatic ptr_t ptr_add(ptr_t a, ptr_t b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[ADDR_W-1:0];
  endfunction

  // Number of bytes between the read and write pointers.
  function automatic ptr_t ptr_dist(ptr_t w, ptr_t r);
    logic [ADDR_W:0] s;
    if (w >= r) begin
      s = {1'b0, w} - {1'b0, r};
    end else begin
      s = {1'b0, w} + DEPTH_X - {1'b0, r};
    end
    return s[ADDR_W-1:0];
  endfunction

  // Fit a count into a result field, zero-extending or masking as needed.
  function automatic fld_t to_fld(ptr_t v);
    logic [FLD_W+ADDR_W-1:0] w;
    w = {{FLD_W{1'b0}}, v};
    return w[FLD_W-1:0];
  endfunction

endpackage

// ----- sv/byte_ring_fifo_with_search_unit.sv -----
// Top level of the byte ring FIFO with search: controller plus datapath.
// Writes, rejected writes, empty reads, ignored kinds and searches with an offset at or past
//   the fill level: result loaded into the output register at accept; one such beat per cycle
//   while the output register is free or being taken.
// Successful reads: the byte comes through the registered read port of the store and reaches
//   the output register from S_FIN. Searches: one stored byte per cycle through the single read
//   port, then S_FIN, with found_offset equal to the used count when nothing matches; no new beat is taken meanwhile.
// Reset (rst_ni low, asynchronous) empties the buffer; the store itself is not cleared.
module byte_ring_fifo_with_search_unit
  import brfs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // wr_byte, search_byte, search_offset, zero pad
  input  logic [KIND_W-1:0]     s_axis_tuser_i,  // kind
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // rd_byte, found_offset, used_count,
                                                 // free_count, zero pad
  output logic [STAT_W-1:0]     m_axis_tuser_o,  // status
  output logic                  m_axis_tlast_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Sequencing of accepts, scans and result hand-off.
  brfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .s_tready_o (s_axis_tready_o)
  );

  // Store, pointers, scan compare and output register.
  brfs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tlast_i  (s_axis_tlast_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- sv/brfs_ctrl.sv -----
// Controller state machine: sequences accepts, the byte scan and result hand-off.
module brfs_ctrl
  import brfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o,
  output logic       s_tready_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        // Take a new beat only when its result can land in the output register.
        s_tready_o   = stat_i.out_free;
        cmd_o.accept = stat_i.in_valid && stat_i.out_free;
        if (cmd_o.accept) begin
          if (stat_i.go_read) begin
            state_d = S_FIN;
          end else if (stat_i.go_scan) begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A search keeps scanning until the datapath reports a hit or the end of the data.
  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !stat_i.scan_done) |=> state_q == S_SCAN)
    else $error("scan left before it was done");

  // A search that needs scanning enters the scan state right after its accept.
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && stat_i.go_scan && !stat_i.go_read) |=> state_q == S_SCAN)
    else $error("search accept did not start a scan");

endmodule

// ----- sv/brfs_dp.sv -----
// Datapath: byte store, ring pointers, search scan and output register.
module brfs_dp
  import brfs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_stat_t            stat_o,
  input  logic                  s_tvalid_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [KIND_W-1:0]     s_tuser_i,
  input  logic                  s_tlast_i,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic [STAT_W-1:0]     m_tuser_o,
  output logic                  m_tlast_o
);

  // Byte store and its registered read port.
  logic [BYTE_W-1:0] byte_store_q [DEPTH];
  logic [BYTE_W-1:0] mem_rdata_q;

  ptr_t rd_ptr_q, wr_ptr_q;

  // Scan state.
  ptr_t              scan_q, used_q, cmp_idx_q;
  logic              cmp_valid_q;
  logic [BYTE_W-1:0] key_q;

  // Result waiting for a read's data or a scan's outcome.
  status_e res_status_q;
  fld_t    res_found_q, res_used_q, res_free_q;
  logic    res_last_q, res_is_read_q;

  // Output register.
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_rd_q;
  status_e           out_status_q;
  fld_t              out_found_q, out_used_q, out_free_q;
  logic              out_last_q;

  // Input beat fields.
  kind_e             kind;
  logic [BYTE_W-1:0] wr_byte, search_byte;
  fld_t              search_offset;

  assign kind          = kind_e'(s_tuser_i);
  assign wr_byte       = s_tdata_i[IN_WR_LSB +: BYTE_W];
  assign search_byte   = s_tdata_i[IN_SB_LSB +: BYTE_W];
  assign search_offset = s_tdata_i[IN_SO_LSB +: FLD_W];

  ptr_t    used_now, used_after, free_after;
  logic    is_full, is_empty, offset_past;
  logic    do_write, go_read, go_scan;
  status_e imm_status;
  fld_t    imm_found;

  // Fill level and the offset test against it.
  assign used_now    = ptr_dist(wr_ptr_q, rd_ptr_q);
  assign is_full     = (used_now == LAST_SLOT);
  assign is_empty    = (used_now == '0);
  assign offset_past = {{ADDR_W{1'b0}}, search_offset} >= {{FLD_W{1'b0}}, used_now};

  // Decode the beat at the input and the result of items that finish at once.
  always_comb begin
    imm_status = ST_OK;
    imm_found  = '0;
    used_after = used_now;
    do_write   = 1'b0;
    go_read    = 1'b0;
    go_scan    = 1'b0;
    case (kind)
      KIND_WRITE: begin
        if (is_full) begin
          imm_status = ST_FULL;
        end else begin
          do_write   = 1'b1;
          used_after = used_now + ptr_t'(1);
        end
      end
      KIND_READ: begin
        if (is_empty) begin
          imm_status = ST_EMPTY;
        end else begin
          go_read    = 1'b1;
          used_after = used_now - ptr_t'(1);
        end
      end
      KIND_SEARCH: begin
        if (offset_past) begin
          imm_status = ST_NOTFOUND;
          imm_found  = to_fld(used_now);
        end else begin
          go_scan = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign free_after = LAST_SLOT - used_after;

  // Scan compare: one stored byte checked per cycle, one read in flight.
  logic scan_more, hit, scan_done, issue;

  assign scan_more = (scan_q < used_q);
  assign hit       = cmp_valid_q && (mem_rdata_q == key_q);
  assign scan_done = hit || (!cmp_valid_q && !scan_more);
  assign issue     = cmd_i.scan && scan_more && !hit;

  // Memory port control.
  logic wr_en, rd_en, load_imm, load_out;
  ptr_t rd_addr;

  assign wr_en    = cmd_i.accept && do_write;
  assign rd_en    = (cmd_i.accept && go_read) || issue;
  assign rd_addr  = issue ? ptr_add(rd_ptr_q, scan_q) : rd_ptr_q;
  assign load_imm = cmd_i.accept && !go_read && !go_scan;
  assign load_out = load_imm || cmd_i.finish;

  // Byte store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byte_store_q[wr_ptr_q] <= wr_byte;
    end
    if (rd_en) begin
      mem_rdata_q <= byte_store_q[rd_addr];
    end
  end

  // Ring pointers and scan control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (cmd_i.accept && go_read) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      cmp_valid_q <= issue;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan registers and the pending result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && go_scan) begin
      scan_q <= ptr_t'(search_offset);
      used_q <= used_now;
      key_q  <= search_byte;
    end else if (issue) begin
      scan_q <= scan_q + ptr_t'(1);
    end
    if (issue) begin
      cmp_idx_q <= scan_q;
    end
    if (cmd_i.accept && (go_read || go_scan)) begin
      res_status_q  <= ST_OK;
      res_found_q   <= '0;
      res_used_q    <= to_fld(used_after);
      res_free_q    <= to_fld(free_after);
      res_last_q    <= s_tlast_i;
      res_is_read_q <= go_read;
    end else if (cmd_i.scan && scan_done) begin
      res_status_q <= hit ? ST_OK : ST_NOTFOUND;
      res_found_q  <= hit ? to_fld(cmp_idx_q) : to_fld(used_q);
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load_imm) begin
      out_rd_q     <= '0;
      out_status_q <= imm_status;
      out_found_q  <= imm_found;
      out_used_q   <= to_fld(used_after);
      out_free_q   <= to_fld(free_after);
      out_last_q   <= s_tlast_i;
    end else if (cmd_i.finish) begin
      out_rd_q     <= res_is_read_q ? mem_rdata_q : '0;
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_used_q   <= res_used_q;
      out_free_q   <= res_free_q;
      out_last_q   <= res_last_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{OUT_PAD_W{1'b0}}, out_free_q, out_used_q, out_found_q, out_rd_q};
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

  // Status toward the controller.
  always_comb begin
    stat_o           = '0;
    stat_o.in_valid  = s_tvalid_i;
    stat_o.out_free  = !out_valid_q || m_tready_i;
    stat_o.go_read   = go_read;
    stat_o.go_scan   = go_scan;
    stat_o.scan_done = scan_done;
  end

  // Pointers stay inside the store.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ptr_q <= LAST_SLOT) && (wr_ptr_q <= LAST_SLOT))
    else $error("ring pointer out of range");

  // The buffer contents do not move while a search scans them.
  a_scan_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |=> $stable(rd_ptr_q) && $stable(wr_ptr_q))
    else $error("pointers changed during a scan");

  // The scan never runs past the fill level taken at its start.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> scan_q <= used_q)
    else $error("scan index beyond fill level");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_valid_q) |-> m_tready_i)
    else $error("output register overwritten");

endmodule

// ----- tb/tb_byte_ring_fifo_with_search_unit.sv -----
// Self-checking testbench for the byte ring FIFO with search, driven over its beat streams.
module tb_byte_ring_fifo_with_search_unit
  import brfs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The input kind that the block ignores.
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  localparam int unsigned CAPACITY    = DEPTH - 1;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned SHOWN_ERRS  = 10;

  // One operation as it travels on the input stream.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] wr_byte;
    logic [BYTE_W-1:0] search_byte;
    fld_t              search_offset;
    logic              last;
  } op_beat_t;

  // One result as it leaves on the output stream.
  typedef struct packed {
    logic [BYTE_W-1:0] rd_byte;
    status_e           status;
    fld_t              found_offset;
    fld_t              used_count;
    fld_t              free_count;
    logic              last;
  } fifo_result_t;

  // Shadow copy of the ring: predicts each result and holds those still due.
  class ring_shadow;
    logic [BYTE_W-1:0] mem [DEPTH];
    int unsigned       rd_ptr;
    int unsigned       wr_ptr;
    fifo_result_t      awaited [$];
    int unsigned       mismatches;

    function new();
      rd_ptr     = 0;
      wr_ptr     = 0;
      mismatches = 0;
    endfunction

    function int unsigned fill_level();
      return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    // Stored byte at a given distance from the oldest one.
    function logic [BYTE_W-1:0] peek(int unsigned idx);
      return mem[(rd_ptr + idx) % DEPTH];
    endfunction

    // Update the ring for one accepted operation and queue its result.
    function void apply_beat(op_beat_t b);
      fifo_result_t r;
      int unsigned  used;
      int unsigned  i;
      used           = fill_level();
      r.rd_byte      = '0;
      r.status       = ST_OK;
      r.found_offset = '0;
      r.last         = b.last;
      case (b.kind)
        KIND_WRITE: begin
          if (used >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            mem[wr_ptr] = b.wr_byte;
            wr_ptr      = (wr_ptr + 1) % DEPTH;
          end
        end
        KIND_READ: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.rd_byte = mem[rd_ptr];
            rd_ptr    = (rd_ptr + 1) % DEPTH;
          end
        end
        KIND_SEARCH: begin
          // Scan from the offset to the newest byte, wrapping round the store.
          r.status       = ST_NOTFOUND;
          r.found_offset = fld_t'(used);
          for (i = b.search_offset; i < used; i++) begin
            if (mem[(rd_ptr + i) % DEPTH] == b.search_byte) begin
              r.status       = ST_OK;
              r.found_offset = fld_t'(i);
              break;
            end
          end
        end
        default: begin
        end
      endcase
      used         = fill_level();
      r.used_count = fld_t'(used);
      r.free_count = fld_t'(CAPACITY - used);
      awaited.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void compare_result(fifo_result_t got);
      fifo_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS) begin
          $display("ERROR: result beat with none due: rd=%h st=%s found=%0d used=%0d free=%0d",
                   got.rd_byte, got.status.name(), got.found_offset, got.used_count,
                   got.free_count);
        end
        return;
      end
      want = awaited.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS) begin
          $display("ERROR: exp rd=%h st=%s found=%0d used=%0d free=%0d last=%b",
                   want.rd_byte, want.status.name(), want.found_offset, want.used_count,
                   want.free_count, want.last);
          $display("       got rd=%h st=%s found=%0d used=%0d free=%0d last=%b",
                   got.rd_byte, got.status.name(), got.found_offset, got.used_count,
                   got.free_count, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [KIND_W-1:0]     s_axis_tuser_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STAT_W-1:0]     m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  ring_shadow  shadow;
  int unsigned burst_left;
  int unsigned ready_left;
  logic        ready_now;
  int unsigned cycle_count;

  byte_ring_fifo_with_search_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      shadow.compare_result('{rd_byte:      m_axis_tdata_o[7:0],
                              status:       status_e'(m_axis_tuser_o),
                              found_offset: m_axis_tdata_o[17:8],
                              used_count:   m_axis_tdata_o[27:18],
                              free_count:   m_axis_tdata_o[37:28],
                              last:         m_axis_tlast_o});
    end
    if (ready_left != 0) begin
      ready_left--;
    end else if (ready_now && $urandom_range(0, 99) < 60) begin
      // Stall for a short while.
      ready_now  = 1'b0;
      ready_left = $urandom_range(0, 5);
    end else begin
      // Accept for a stretch, now and then a long one without stalls.
      ready_now  = 1'b1;
      ready_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 23);
    end
    m_axis_tready_i <= ready_now;
  end

  function automatic op_beat_t make_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] wb,
                                       logic [BYTE_W-1:0] sb, fld_t off, logic last);
    op_beat_t b;
    b.kind          = kind;
    b.wr_byte       = wb;
    b.search_byte   = sb;
    b.search_offset = off;
    b.last          = last;
    return b;
  endfunction

  // Random operation with the given write and read shares in percent.
  function automatic op_beat_t rand_op(int unsigned wr_pct, int unsigned rd_pct);
    op_beat_t    b;
    int unsigned roll;
    int unsigned used;
    roll            = $urandom_range(0, 99);
    used            = shadow.fill_level();
    b.kind          = KIND_SEARCH;
    b.wr_byte       = ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom)
                                                  : BYTE_W'($urandom_range(0, 15));
    b.search_byte   = BYTE_W'($urandom);
    b.search_offset = fld_t'($urandom);
    b.last          = 1'($urandom);
    if (roll < 2) begin
      b.kind = KIND_IGNORED;
    end else if (roll < 2 + wr_pct) begin
      b.kind = KIND_WRITE;
    end else if (roll < 2 + wr_pct + rd_pct) begin
      b.kind = KIND_READ;
    end else begin
      // Mostly offsets inside the fill level, often aimed at a byte that is stored.
      if ($urandom_range(0, 99) < 80) begin
        b.search_offset = fld_t'($urandom_range(0, used));
      end
      if (b.search_offset < used && $urandom_range(0, 99) < 60) begin
        b.search_byte = shadow.peek($urandom_range(b.search_offset, used - 1));
      end
    end
    return b;
  endfunction

  // Send one beat, then pause between bursts.
  task automatic send_op(op_beat_t b);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_DATA_W'({b.search_offset, b.search_byte, b.wr_byte});
    s_axis_tuser_i  <= b.kind;
    s_axis_tlast_i  <= b.last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    shadow.apply_beat(b);
    gap = 0;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 29);
      if ($urandom_range(0, 99) < 70) begin
        gap = $urandom_range(1, 8);
      end
    end
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    shadow          = new();
    cycle_count     = 0;
    burst_left      = 0;
    ready_left      = 0;
    ready_now       = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_WRITE;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty buffer, ignored kind, field extremes and search corners.
    send_op(make_op(KIND_READ, 8'h00, 8'h00, 10'd0, 1'b1));
    send_op(make_op(KIND_SEARCH, 8'h00, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_IGNORED, 8'h00, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_WRITE, 8'h00, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_WRITE, 8'hFF, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_WRITE, 8'hA5, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_WRITE, 8'h5A, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_WRITE, 8'hFF, 8'h00, 10'd0, 1'b1));
    send_op(make_op(KIND_SEARCH, 8'h00, 8'hFF, 10'd0, 1'b0));
    send_op(make_op(KIND_SEARCH, 8'h00, 8'hFF, 10'd2, 1'b0));
    send_op(make_op(KIND_SEARCH, 8'h00, 8'h5A, 10'd4, 1'b0));
    send_op(make_op(KIND_SEARCH, 8'hFF, 8'hFF, 10'd1023, 1'b1));
    send_op(make_op(KIND_SEARCH, 8'h00, 8'hA5, 10'd5, 1'b0));
    send_op(make_op(KIND_READ, 8'h00, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_READ, 8'hFF, 8'hFF, 10'd1023, 1'b1));
    send_op(make_op(KIND_SEARCH, 8'h00, 8'h00, 10'd0, 1'b0));
    send_op(make_op(KIND_IGNORED, 8'hFF, 8'hFF, 10'd1023, 1'b1));

    // Balanced traffic at a low fill level, with empty reads.
    repeat (150) send_op(rand_op(45, 35));
    // Climb to a high fill level so that searches run over long spans.
    repeat (450) send_op(rand_op(90, 3));
    // Mostly reads from a well filled buffer, then a balanced mix again.
    repeat (150) send_op(rand_op(8, 80));
    repeat (80) send_op(rand_op(40, 40));

    // Let the last results drain out.
    s_axis_tvalid_i <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
